### rtl/lsm_pkg.sv
package lsm_pkg;

  // Default sizes of the block.
  localparam int PATTERN_MAX_DEFAULT      = 16;
  localparam int LINE_NUMBER_BITS_DEFAULT = 32;

  // Number of pattern bytes that the configuration registers can hold.
  localparam int REG_BYTES = 16;

  // Configuration port shape.
  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 64;

  // Widths of the fixed fields.
  localparam int PATTERN_LENGTH_BITS = 5;
  localparam int OUT_NUMBER_BITS     = 32;
  localparam int OUT_TDATA_BITS      = 40;

  // Register indexes on the configuration port.
  localparam logic [CFG_INDEX_BITS-1:0] REG_PATTERN_LOW  = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_PATTERN_HIGH = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_PATTERN_LEN  = 2'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_FOLD_CASE    = 2'd3;

  // Character codes.
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;
  localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
  localparam logic [7:0] CHAR_NUL     = 8'h00;

  // Control handed from the top level to every window cell.
  typedef struct packed {
    logic shift;
    logic fold_en;
  } lsm_ctl_t;

  // Folds ASCII upper case to lower case when enabled.
  function automatic logic [7:0] fold_byte(input logic [7:0] c, input logic en);
    logic [7:0] r;
    r = c;
    if (en && (c >= CHAR_UPPER_A) && (c <= CHAR_UPPER_Z)) begin
      r = c + (CHAR_LOWER_A - CHAR_UPPER_A);
    end
    return r;
  endfunction

endpackage

### rtl/lsm_cell.sv
module lsm_cell #(
  parameter int PATTERN_MAX = lsm_pkg::PATTERN_MAX_DEFAULT,
  parameter int CELL_INDEX  = 0,
  localparam int COUNT_BITS = $clog2(PATTERN_MAX + 1)
) (
  input  logic                     clk,
  input  lsm_pkg::lsm_ctl_t        ctl,
  input  logic [7:0]               shift_in,
  input  logic [PATTERN_MAX*8-1:0] pattern_bytes,
  input  logic [COUNT_BITS-1:0]    eff_len,
  output logic [7:0]               held_byte,
  output logic                     hit
);

  logic [7:0] aligned;
  logic       care;

  // The pattern is aligned to the newest end of the window: this cell
  // meets pattern byte k when CELL_INDEX + eff_len - PATTERN_MAX equals k.
  always_comb begin
    aligned = lsm_pkg::CHAR_NUL;
    care    = 1'b0;
    for (int k = 0; k < PATTERN_MAX; k++) begin
      if (int'(eff_len) == PATTERN_MAX - CELL_INDEX + k) begin
        aligned = pattern_bytes[k*8 +: 8];
        care    = 1'b1;
      end
    end
  end

  // The byte that enters this cell is the one compared.
  assign hit = !care ||
               (lsm_pkg::fold_byte(shift_in, ctl.fold_en) ==
                lsm_pkg::fold_byte(aligned, ctl.fold_en));

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      held_byte <= shift_in;
    end
  end

endmodule

### rtl/line_substring_matcher.sv
// Line substring matcher.
// The file arrives as a byte stream on the slave channel, one byte per beat,
// with s_tlast marking the final byte of the file. A line ends at a newline
// byte (which belongs to the line) or at the final byte. For each finished
// line one beat leaves on the master channel with the match flag and the
// one-based line number; bytes that do not end a line produce no beat.
// The user must set the pattern, its length and the case folding mode
// through the plain write port (cfg_we, cfg_index, cfg_data) only while no
// beat is in flight; the block does not enforce this. Throughput is one byte
// per clock cycle while not stalled: the window is a row of PATTERN_MAX byte
// cells that shift together, and each cell compares the byte entering it
// with its aligned pattern byte in the same cycle. A result beat appears on
// the master side in the cycle after the byte that ends its line. The result
// sits in one output register; while a result beat waits and the receiver
// is not ready, s_tready is low, so the slave side stalls until the waiting
// beat is taken. Reset clears the configuration, the line state and the line
// counter and empties the output register; no clearing pass is needed.
module line_substring_matcher #(
  parameter int PATTERN_MAX      = lsm_pkg::PATTERN_MAX_DEFAULT,
  parameter int LINE_NUMBER_BITS = lsm_pkg::LINE_NUMBER_BITS_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  // Slave side: tdata holds data_byte in bits 7:0; tlast is end_of_file.
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [7:0]                         s_tdata,
  input  logic                               s_tlast,
  // Master side: tdata holds line_matched in bit 0, line_number in bits
  // 32:1, and zero padding in bits 39:33.
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [lsm_pkg::OUT_TDATA_BITS-1:0] m_tdata,
  // Configuration write port.
  input  logic                               cfg_we,
  input  logic [lsm_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [lsm_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

  localparam int COUNT_BITS = $clog2(PATTERN_MAX + 1);
  // Pattern bytes beyond the registers or beyond the window read as zero.
  localparam int CAP = (PATTERN_MAX < lsm_pkg::REG_BYTES) ? PATTERN_MAX
                                                           : lsm_pkg::REG_BYTES;

  // Configuration registers.
  logic [63:0]                               pattern_low;
  logic [63:0]                               pattern_high;
  logic [lsm_pkg::PATTERN_LENGTH_BITS-1:0]   pattern_length;
  logic                                      fold_case;

  // Line state.
  logic [COUNT_BITS-1:0]       bytes_in_line;
  logic [COUNT_BITS-1:0]       bytes_in_line_next;
  logic                        zero_seen;
  logic                        match_found;
  logic                        match_next;
  logic [LINE_NUMBER_BITS-1:0] lines_done;
  logic [LINE_NUMBER_BITS-1:0] lines_done_next;

  // Output register.
  logic                                 out_valid;
  logic                                 out_matched;
  logic [lsm_pkg::OUT_NUMBER_BITS-1:0]  out_number;
  logic [lsm_pkg::OUT_NUMBER_BITS-1:0]  number_sat;

  logic [PATTERN_MAX*8-1:0] pattern_bytes;
  logic [127:0]             pattern_regs;
  logic [COUNT_BITS-1:0]    eff_len;
  logic [7:0]               cell_byte [PATTERN_MAX];
  logic [PATTERN_MAX-1:0]   cell_hit;
  lsm_pkg::lsm_ctl_t        ctl;

  logic accept;
  logic zero_now;
  logic line_end;
  logic window_hit;

  assign accept   = s_tvalid && s_tready;
  assign s_tready = !out_valid || m_tready;
  assign m_tvalid = out_valid;
  assign m_tdata  = {{(lsm_pkg::OUT_TDATA_BITS - lsm_pkg::OUT_NUMBER_BITS - 1){1'b0}},
                     out_number, out_matched};

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_low    <= '0;
      pattern_high   <= '0;
      pattern_length <= '0;
      fold_case      <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        lsm_pkg::REG_PATTERN_LOW:  pattern_low    <= cfg_data[63:0];
        lsm_pkg::REG_PATTERN_HIGH: pattern_high   <= cfg_data[63:0];
        lsm_pkg::REG_PATTERN_LEN:  pattern_length <= cfg_data[lsm_pkg::PATTERN_LENGTH_BITS-1:0];
        lsm_pkg::REG_FOLD_CASE:    fold_case      <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Pattern bytes as the window sees them, byte 0 lowest.
  assign pattern_regs = {pattern_high, pattern_low};

  for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_pattern
    if (k < lsm_pkg::REG_BYTES) begin : g_reg
      assign pattern_bytes[k*8 +: 8] = pattern_regs[k*8 +: 8];
    end else begin : g_zero
      assign pattern_bytes[k*8 +: 8] = lsm_pkg::CHAR_NUL;
    end
  end

  // The effective length, at most CAP, stops at the first zero pattern byte.
  always_comb begin
    if (pattern_length > lsm_pkg::PATTERN_LENGTH_BITS'(CAP)) begin
      eff_len = COUNT_BITS'(CAP);
    end else begin
      eff_len = COUNT_BITS'(pattern_length);
    end
    for (int k = CAP - 1; k >= 0; k--) begin
      if ((k < int'(pattern_length)) && (pattern_bytes[k*8 +: 8] == lsm_pkg::CHAR_NUL)) begin
        eff_len = COUNT_BITS'(k);
      end
    end
  end

  // A zero byte freezes the window until the line ends.
  assign zero_now    = (s_tdata == lsm_pkg::CHAR_NUL);
  assign line_end    = (s_tdata == lsm_pkg::CHAR_NEWLINE) || s_tlast;
  assign ctl.shift   = accept && !zero_now && !zero_seen;
  assign ctl.fold_en = fold_case;

  // The row of window cells; the newest byte enters the highest cell.
  for (genvar i = 0; i < PATTERN_MAX; i++) begin : g_cell
    logic [7:0] shift_in;
    if (i == PATTERN_MAX - 1) begin : g_head
      assign shift_in = s_tdata;
    end else begin : g_body
      assign shift_in = cell_byte[i+1];
    end
    lsm_cell #(
      .PATTERN_MAX(PATTERN_MAX),
      .CELL_INDEX (i)
    ) u_cell (
      .clk          (clk),
      .ctl          (ctl),
      .shift_in     (shift_in),
      .pattern_bytes(pattern_bytes),
      .eff_len      (eff_len),
      .held_byte    (cell_byte[i]),
      .hit          (cell_hit[i])
    );
  end

  always_comb begin
    bytes_in_line_next = bytes_in_line;
    if (ctl.shift && (bytes_in_line != COUNT_BITS'(PATTERN_MAX))) begin
      bytes_in_line_next = bytes_in_line + 1'b1;
    end
  end

  // A hit only counts once the line has filled the compared part of the window.
  assign window_hit = ctl.shift && (eff_len != '0) && (bytes_in_line_next >= eff_len) &&
                      (&cell_hit);
  assign match_next = match_found || window_hit;

  assign lines_done_next = (&lines_done) ? lines_done : lines_done + 1'b1;

  if (LINE_NUMBER_BITS > lsm_pkg::OUT_NUMBER_BITS) begin : g_sat
    assign number_sat = (lines_done_next[LINE_NUMBER_BITS-1:lsm_pkg::OUT_NUMBER_BITS] != '0)
                        ? '1 : lines_done_next[lsm_pkg::OUT_NUMBER_BITS-1:0];
  end else begin : g_ext
    assign number_sat = lsm_pkg::OUT_NUMBER_BITS'(lines_done_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_in_line <= '0;
      zero_seen     <= 1'b0;
      match_found   <= 1'b0;
      lines_done    <= '0;
      out_valid     <= 1'b0;
    end else begin
      // A new result beat takes the register in the same cycle that the
      // waiting one leaves it.
      if (accept && line_end) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
      if (accept) begin
        if (line_end) begin
          bytes_in_line <= '0;
          zero_seen     <= 1'b0;
          match_found   <= 1'b0;
          lines_done    <= s_tlast ? '0 : lines_done_next;
        end else begin
          bytes_in_line <= bytes_in_line_next;
          zero_seen     <= zero_seen || zero_now;
          match_found   <= match_next;
        end
      end
    end
  end

  // Result payload; an empty pattern matches every line.
  always_ff @(posedge clk) begin
    if (accept && line_end) begin
      out_matched <= (eff_len == '0) || match_next;
      out_number  <= number_sat;
    end
  end

`ifndef SYNTHESIS
  // A byte that ends a line always produces a result beat in the next cycle.
  a_line_end_result: assert property (@(posedge clk) disable iff (rst)
    (accept && line_end) |=> m_tvalid)
    else $error("line end without result beat");

  // The fill count never passes the window depth.
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    bytes_in_line <= COUNT_BITS'(PATTERN_MAX))
    else $error("window fill count out of range");

  // The final byte of a file restarts the line numbering.
  a_file_restart: assert property (@(posedge clk) disable iff (rst)
    (accept && s_tlast) |=> (lines_done == '0))
    else $error("line counter not cleared at end of file");

  // Line numbers are one-based.
  a_number_nonzero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (out_number != '0))
    else $error("zero line number on result beat");
`endif

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps

module testbench;

  localparam int WINDOW_BYTES = lsm_pkg::PATTERN_MAX_DEFAULT;

  // One byte of the file as it travels on the slave side.
  typedef struct {
    logic [7:0] value;
    logic       last;
  } file_beat_t;

  // What the block should report for one finished line.
  typedef struct {
    logic                                matched;
    logic [lsm_pkg::OUT_NUMBER_BITS-1:0] number;
  } line_verdict_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                               s_tvalid = 1'b0;
  logic                               s_tready;
  logic [7:0]                         s_tdata = '0;
  logic                               s_tlast = 1'b0;
  logic                               m_tvalid;
  logic                               m_tready = 1'b0;
  logic [lsm_pkg::OUT_TDATA_BITS-1:0] m_tdata;
  logic                               cfg_we = 1'b0;
  logic [lsm_pkg::CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [lsm_pkg::CFG_DATA_BITS-1:0]  cfg_data = '0;

  line_substring_matcher dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),   // bits 7:0 data_byte
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),   // bit 0 line_matched, bits 32:1 line_number, rest zero
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // A 4 ns clock.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Bytes waiting to be offered, and the line verdicts still owed by the block.
  file_beat_t    bytes_to_send[$];
  line_verdict_t verdicts_due[$];
  int            beats_queued = 0;
  int            mismatches = 0;

  // Our own view of the configuration registers, updated when a write lands.
  logic [63:0]                             shadow_pat_low = '0;
  logic [63:0]                             shadow_pat_high = '0;
  logic [lsm_pkg::PATTERN_LENGTH_BITS-1:0] shadow_pat_len = '0;
  logic                                    shadow_fold = 1'b0;

  // Line state of the matcher as we predict it. The window holds the most
  // recent searchable bytes of the line with the newest byte at the top.
  logic [7:0]                          window_bytes[WINDOW_BYTES];
  int                                  window_fill = 0;
  logic                                zero_in_line = 1'b0;
  logic                                hit_in_line = 1'b0;
  logic [lsm_pkg::OUT_NUMBER_BITS-1:0] lines_seen = '0;

  // The pattern that the stimulus of the current phase is built around.
  logic [7:0] phase_pat[lsm_pkg::REG_BYTES];
  int         phase_len = 0;
  logic       phase_fold = 1'b0;

  // Set once by the stimulus to ask the receiver for its long hold-off.
  logic hold_wanted = 1'b0;

  initial begin
    for (int k = 0; k < WINDOW_BYTES; k++) window_bytes[k] = '0;
  end

  // Pattern byte k as the registers hold it; positions past the sixteen
  // register bytes or past the window read as zero.
  function automatic logic [7:0] stored_pattern_byte(int k);
    if (k >= lsm_pkg::REG_BYTES || k >= WINDOW_BYTES) return lsm_pkg::CHAR_NUL;
    if (k < 8) return shadow_pat_low[8*k +: 8];
    return shadow_pat_high[8*(k-8) +: 8];
  endfunction

  // The pattern is cut short at its first zero byte.
  function automatic int pattern_span();
    int n;
    n = 0;
    while (n < shadow_pat_len && stored_pattern_byte(n) != lsm_pkg::CHAR_NUL) n++;
    return n;
  endfunction

  function automatic logic [7:0] to_lower(logic [7:0] c);
    if (shadow_fold && c >= lsm_pkg::CHAR_UPPER_A && c <= lsm_pkg::CHAR_UPPER_Z)
      return c | 8'h20;
    return c;
  endfunction

  // Advances the predicted line state by one accepted byte and, where the
  // byte ends a line, queues the verdict for that line.
  function automatic void take_byte(logic [7:0] b, logic last);
    int            span;
    logic          same;
    line_verdict_t verdict;
    span = pattern_span();
    if (b == lsm_pkg::CHAR_NUL) begin
      zero_in_line = 1'b1;
    end else if (!zero_in_line) begin
      for (int k = 0; k < WINDOW_BYTES - 1; k++) window_bytes[k] = window_bytes[k+1];
      window_bytes[WINDOW_BYTES-1] = b;
      if (window_fill < WINDOW_BYTES) window_fill++;
      if (span > 0 && window_fill >= span) begin
        same = 1'b1;
        for (int j = 0; j < span; j++) begin
          if (to_lower(window_bytes[WINDOW_BYTES-span+j]) != to_lower(stored_pattern_byte(j)))
            same = 1'b0;
        end
        if (same) hit_in_line = 1'b1;
      end
    end
    if (b == lsm_pkg::CHAR_NEWLINE || last) begin
      if (lines_seen != '1) lines_seen++;
      verdict.matched = (span == 0) || hit_in_line;
      verdict.number = lines_seen;
      verdicts_due.push_back(verdict);
      for (int k = 0; k < WINDOW_BYTES; k++) window_bytes[k] = '0;
      window_fill = 0;
      zero_in_line = 1'b0;
      hit_in_line = 1'b0;
      if (last) lines_seen = '0;
    end
  endfunction

  task automatic flag_mismatch(input string what, input logic [31:0] want,
                               input logic [31:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t ns: %s: expected 0x%0h, got 0x%0h", $time, what, want, got);
  endtask

  // Sender. It offers bytes in bursts of random length separated by random
  // gaps, and a byte once offered stays on the bus until it is taken. Each
  // accepted byte is fed to the predictor at the edge that accepts it.
  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk) begin
    file_beat_t nxt;
    logic       offer;
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tlast  <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) take_byte(s_tdata, s_tlast);
      if (!s_tvalid || s_tready) begin
        offer = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (bytes_to_send.size() > 0) begin
          nxt = bytes_to_send.pop_front();
          offer = 1'b1;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 48);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
          end else begin
            burst_left--;
          end
        end
        s_tvalid <= offer;
        if (offer) begin
          s_tdata <= nxt.value;
          s_tlast <= nxt.last;
        end
      end
    end
  end

  // Receiver. It switches between runs of steady readiness, runs of stalling
  // and runs of random readiness. Once asked, it also holds off so that the
  // block fills up and has to stall its input.
  int   run_left = 0;
  int   run_kind = 0;
  int   hold_left = 0;
  logic hold_given = 1'b0;

  always @(posedge clk) begin
    logic ready;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (hold_wanted && !hold_given) begin
        hold_given = 1'b1;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        ready = 1'b0;
      end else begin
        if (run_left == 0) begin
          run_kind = $urandom_range(0, 9);
          run_left = (run_kind < 5) ? $urandom_range(1, 40) :
                     (run_kind < 8) ? $urandom_range(1, 12) : $urandom_range(1, 30);
        end
        run_left--;
        ready = (run_kind < 5) ? 1'b1 : (run_kind < 8) ? 1'b0 : 1'($urandom_range(0, 1));
      end
      m_tready <= ready;
    end
  end

  // Result checker: every beat taken on the master side is compared, field by
  // field, with the oldest verdict still owed.
  always @(posedge clk) begin
    line_verdict_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (verdicts_due.size() == 0) begin
        flag_mismatch("result beat with no line finished", '0, m_tdata[32:1]);
      end else begin
        want = verdicts_due.pop_front();
        if (m_tdata[0] !== want.matched)
          flag_mismatch($sformatf("line_matched of line %0d", want.number),
                        32'(want.matched), 32'(m_tdata[0]));
        if (m_tdata[32:1] !== want.number)
          flag_mismatch("line_number", want.number, m_tdata[32:1]);
      end
    end
  end

  // A register write lands at the edge where cfg_we is seen high; the shadow
  // copy is updated at that same edge.
  task automatic write_reg(input logic [lsm_pkg::CFG_INDEX_BITS-1:0] idx,
                           input logic [63:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      lsm_pkg::REG_PATTERN_LOW:  shadow_pat_low = value;
      lsm_pkg::REG_PATTERN_HIGH: shadow_pat_high = value;
      lsm_pkg::REG_PATTERN_LEN:  shadow_pat_len = value[lsm_pkg::PATTERN_LENGTH_BITS-1:0];
      lsm_pkg::REG_FOLD_CASE:    shadow_fold = value[0];
      default: ;
    endcase
  endtask

  // Writes the phase pattern, its length and the folding mode.
  task automatic program_pattern();
    logic [63:0] low_word, high_word;
    for (int k = 0; k < 8; k++) begin
      low_word[8*k +: 8]  = phase_pat[k];
      high_word[8*k +: 8] = phase_pat[k+8];
    end
    write_reg(lsm_pkg::REG_PATTERN_LOW, low_word);
    write_reg(lsm_pkg::REG_PATTERN_HIGH, high_word);
    write_reg(lsm_pkg::REG_PATTERN_LEN, 64'(phase_len));
    write_reg(lsm_pkg::REG_FOLD_CASE, 64'(phase_fold));
  endtask

  // Waits until every byte has gone in and every verdict has come out, then
  // lets the clock run on for a byte that ended no line.
  task automatic wait_idle();
    do @(negedge clk);
    while (bytes_to_send.size() != 0 || s_tvalid || verdicts_due.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic push_beat(input logic [7:0] value, input logic last);
    file_beat_t fb;
    fb.value = value;
    fb.last = last;
    bytes_to_send.push_back(fb);
    beats_queued++;
  endtask

  // Line content: mostly the letters the patterns are built from, now and
  // then a zero byte, a stray newline or any byte at all.
  function automatic logic [7:0] random_text_byte();
    int r;
    r = $urandom_range(0, 99);
    if (r < 30) return "a";
    if (r < 50) return "b";
    if (r < 60) return "A";
    if (r < 70) return "B";
    if (r < 75) return "c";
    if (r < 78) return lsm_pkg::CHAR_NUL;
    if (r < 80) return lsm_pkg::CHAR_NEWLINE;
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [7:0] random_pattern_byte();
    int r;
    r = $urandom_range(0, 99);
    if (r < 35) return "a";
    if (r < 60) return "b";
    if (r < 75) return "A";
    if (r < 88) return "B";
    if (r < 91) return lsm_pkg::CHAR_NEWLINE;
    if (r < 94) return lsm_pkg::CHAR_NUL;
    return 8'($urandom_range(0, 255));
  endfunction

  // Copies the phase pattern into the stream, with letters flipped in case
  // when folding is on, and now and then with its last byte missing.
  task automatic insert_pattern();
    int         n;
    logic [7:0] b;
    n = phase_len;
    if (n > 0 && $urandom_range(0, 4) == 0) n--;
    for (int j = 0; j < n; j++) begin
      b = phase_pat[j];
      if (phase_fold && (b | 8'h20) >= "a" && (b | 8'h20) <= "z" && $urandom_range(0, 1))
        b = b ^ 8'h20;
      push_beat(b, 1'b0);
    end
  endtask

  // Queues whole lines, about half of them holding the pattern, until the
  // given number of bytes is reached. Some lines end the file, sometimes on a
  // byte other than a newline, and a phase may stop in the middle of a line.
  task automatic queue_lines(input int target, input int longest);
    int   stop, text_len, at;
    logic eof;
    stop = beats_queued + target;
    while (beats_queued < stop) begin
      text_len = ($urandom_range(0, 9) == 0) ? $urandom_range(longest, 2 * longest + 8)
                                             : $urandom_range(0, longest);
      at = (phase_len > 0 && $urandom_range(0, 1)) ? $urandom_range(0, text_len) : -1;
      for (int k = 0; k <= text_len; k++) begin
        if (k == at) insert_pattern();
        if (k < text_len) push_beat(random_text_byte(), 1'b0);
      end
      eof = ($urandom_range(0, 7) == 0);
      push_beat((eof && $urandom_range(0, 1)) ? random_text_byte() : lsm_pkg::CHAR_NEWLINE,
                eof);
    end
    if ($urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 5)) push_beat(random_text_byte(), 1'b0);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Registers as reset leave them: the empty pattern matches every line,
    // including one that holds a zero byte and one ended by end of file.
    @(negedge clk);
    push_beat(8'hFF, 1'b0);
    push_beat(lsm_pkg::CHAR_NUL, 1'b0);
    push_beat(lsm_pkg::CHAR_NEWLINE, 1'b0);
    push_beat(8'h7E, 1'b1);
    wait_idle();

    // A pattern ending in a newline, compared with case folding. The second
    // line has a zero byte in front of its newline, so it must not match.
    phase_pat[0] = "A";
    phase_pat[1] = "b";
    phase_pat[2] = lsm_pkg::CHAR_NEWLINE;
    for (int k = 3; k < lsm_pkg::REG_BYTES; k++) phase_pat[k] = "q";
    phase_len = 3;
    phase_fold = 1'b1;
    program_pattern();
    @(negedge clk);
    push_beat("a", 1'b0);
    push_beat("B", 1'b0);
    push_beat(lsm_pkg::CHAR_NEWLINE, 1'b0);
    push_beat("a", 1'b0);
    push_beat("b", 1'b0);
    push_beat(lsm_pkg::CHAR_NUL, 1'b0);
    push_beat(lsm_pkg::CHAR_NEWLINE, 1'b0);
    push_beat("Z", 1'b1);
    wait_idle();

    // A zero byte inside the pattern cuts it short; the line ends with the
    // file on a byte that is not a newline.
    phase_pat[0] = "p";
    phase_pat[1] = "q";
    phase_pat[2] = "r";
    phase_pat[3] = "s";
    phase_pat[4] = lsm_pkg::CHAR_NUL;
    for (int k = 5; k < lsm_pkg::REG_BYTES; k++) phase_pat[k] = "x";
    phase_len = 9;
    phase_fold = 1'b0;
    program_pattern();
    @(negedge clk);
    push_beat("p", 1'b0);
    push_beat("q", 1'b0);
    push_beat("r", 1'b0);
    push_beat("s", 1'b1);
    wait_idle();

    // Random phases, each with a fresh configuration written while idle.
    for (int ph = 0; ph < 24; ph++) begin
      for (int k = 0; k < lsm_pkg::REG_BYTES; k++) phase_pat[k] = random_pattern_byte();
      phase_len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 16) : $urandom_range(1, 4);
      phase_fold = 1'($urandom_range(0, 1));
      case (ph)
        0: begin
          // Longest pattern, folding on.
          for (int k = 0; k < lsm_pkg::REG_BYTES; k++)
            phase_pat[k] = ($urandom_range(0, 1)) ? "a" : "B";
          phase_len = 16;
          phase_fold = 1'b1;
        end
        1: begin
          phase_len = 0;
          phase_fold = 1'b0;
        end
        2: begin
          // Every pattern register bit set.
          for (int k = 0; k < lsm_pkg::REG_BYTES; k++) phase_pat[k] = 8'hFF;
          phase_len = 16;
          phase_fold = 1'b0;
        end
        3: begin
          phase_pat[0] = "a";
          phase_len = 1;
        end
        4: begin
          phase_len = 16;
          phase_pat[$urandom_range(1, 15)] = lsm_pkg::CHAR_NUL;
        end
        default: ;
      endcase
      program_pattern();
      @(negedge clk);
      if (ph == 3) begin
        // Short lines while the receiver holds off, so that the output
        // register fills and the slave side has to stall.
        hold_wanted = 1'b1;
        queue_lines(75, 2);
      end else if (ph == 5) begin
        // The sender stops half way until every verdict has arrived.
        queue_lines(35, 12);
        wait_idle();
        @(negedge clk);
        queue_lines(40, 12);
      end else begin
        queue_lines(75, 12);
      end
      wait_idle();
    end

    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("** line_substring_matcher: PASSED **");
    end else begin
      $display("** line_substring_matcher: FAILED **");
    end
    $finish;
  end

  // Guard against a hang: far longer than the slowest correct run.
  initial begin
    #2_000_000;
    $display("** line_substring_matcher: FAILED **");
    $finish;
  end

endmodule
